// ===== rtl/core/aets_pkg.sv =====
package aets_pkg;

  // Fixed field widths
  localparam int THREAD_W = 6;
  localparam int CPU_ID_W = 2;
  localparam int CMD_W    = 2;

  // Thread ID space that the pin table covers
  localparam int TID_NUM = 1 << THREAD_W;

  // Parameter defaults
  localparam int DEF_MAX_THREADS = 64;
  localparam int DEF_NUM_CPUS    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_WAKE  = 2'd1,
    CMD_SCHED = 2'd2,
    CMD_PIN   = 2'd3
  } cmd_t;

  // Pin table write request
  typedef struct packed {
    logic                en;
    logic [THREAD_W-1:0] tid;
    logic [CPU_ID_W-1:0] cpu;
  } pin_wr_t;

  // Pin table read result
  typedef struct packed {
    logic                valid;
    logic [CPU_ID_W-1:0] cpu;
  } pin_rd_t;

endpackage

// ===== rtl/core/aets_stack_unit.sv =====
// Shared stack pointer arithmetic: full/empty checks, slot and updated count
module aets_stack_unit #(
  parameter int  MAX_THREADS = aets_pkg::DEF_MAX_THREADS,
  localparam int CNT_W       = $clog2(MAX_THREADS + 1),
  localparam int SLOT_W      = $clog2(MAX_THREADS)
) (
  input  logic [CNT_W-1:0]  count,
  input  logic              push,
  output logic              full,
  output logic              empty,
  output logic [SLOT_W-1:0] slot,
  output logic [CNT_W-1:0]  count_next
);

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;

  assign cnt_inc = count + CNT_W'(1);
  assign cnt_dec = count - CNT_W'(1);

  assign full  = (count == CNT_W'(MAX_THREADS));
  assign empty = (count == '0);

  // push writes at count, pop reads at count - 1
  assign slot       = push ? count[SLOT_W-1:0] : cnt_dec[SLOT_W-1:0];
  assign count_next = push ? cnt_inc : cnt_dec;

endmodule

// ===== rtl/core/aets_pin_table.sv =====
// Per-thread CPU pin table; valid bits give the unpinned reset state
module aets_pin_table (
  input  logic                                clk,
  input  logic                                rst,
  input  aets_pkg::pin_wr_t                   wr,
  input  logic [aets_pkg::THREAD_W-1:0]       rd_tid,
  output aets_pkg::pin_rd_t                   rd
);

  logic [aets_pkg::CPU_ID_W-1:0] pin_mem [aets_pkg::TID_NUM];
  logic [aets_pkg::TID_NUM-1:0]  pinned;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pinned <= '0;
    end else if (wr.en) begin
      pinned[wr.tid] <= 1'b1;
    end
  end

  // Target CPU storage, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      pin_mem[wr.tid] <= wr.cpu;
    end
    rd.cpu   <= pin_mem[rd_tid];
    rd.valid <= pinned[rd_tid];
  end

endmodule

// ===== rtl/core/active_expired_thread_scheduler.sv =====
// Active/expired thread scheduler with per-CPU stacks and CPU pinning.
// Input channel (in_valid / in_stall) carries one command word: add, wake,
// schedule or pin. A word is taken when in_valid is high and in_stall low;
// in_stall stays high until the current command has finished.
// Output channel (out_valid / out_stall) returns one result word per
// command: next_valid, chosen_thread, status. The result sits in an output
// register, so a new command is taken while a result waits to be taken.
// Add, wake and pin go from the execute step straight to the finish step.
// Schedule first checks the CPU's own stack, then pops the active run
// stack, swapping active and expired when the active one is empty, and
// ends with no thread when both are empty; a popped thread pinned to
// another CPU is migrated to that CPU's stack and the search starts again.
// The next word can be taken in the cycle after the result is loaded.
// All work goes through one stack pointer unit and single-port stack
// memories under a small sequencer.
// A receiver stall holds the result word; a finished command then waits in
// its last step until the output register is free.
// Reset (rst, synchronous) empties all stacks, makes stack A active and
// unpins all threads at once; no clearing pass is needed.
module active_expired_thread_scheduler #(
  parameter int MAX_THREADS = aets_pkg::DEF_MAX_THREADS,
  parameter int NUM_CPUS    = aets_pkg::DEF_NUM_CPUS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aets_pkg::CMD_W-1:0]    cmd,
  input  logic [aets_pkg::THREAD_W-1:0] thread_id,
  input  logic [aets_pkg::CPU_ID_W-1:0] cpu_id,
  input  logic                          outgoing_valid,
  input  logic [aets_pkg::THREAD_W-1:0] outgoing_thread,
  input  logic                          outgoing_running,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          next_valid,
  output logic [aets_pkg::THREAD_W-1:0] chosen_thread,
  output logic                          status
);

  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int TW     = aets_pkg::THREAD_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CPU_CHK,
    ST_CPU_RD,
    ST_RUN_CHK,
    ST_RUN_POP,
    ST_RUN_RD,
    ST_PIN_CHK,
    ST_FINISH
  } state_t;

  state_t state;

  // Latched command word
  aets_pkg::cmd_t                cmd_q;
  logic [TW-1:0]                 tid_q;
  logic [aets_pkg::CPU_ID_W-1:0] cpu_q;
  logic                          requeue_q;
  logic [TW-1:0]                 othr_q;

  // Result being built
  logic          found_q;
  logic [TW-1:0] next_q;
  logic          status_q;
  logic [TW-1:0] cur_thread;

  // Stack state
  logic [CNT_W-1:0] stack_a_count;
  logic [CNT_W-1:0] stack_b_count;
  logic             a_is_active;
  logic [CNT_W-1:0] cpu_counts [NUM_CPUS];

  // Memories
  logic [TW-1:0] run_mem [2**(SLOT_W+1)];
  logic [TW-1:0] cpu_mem [2**(CPU_W+SLOT_W)];
  logic [TW-1:0] run_rdata;
  logic [TW-1:0] cpu_rdata;

  // Shared unit hookup
  logic [CNT_W-1:0]  unit_cnt;
  logic              unit_push;
  logic              unit_full;
  logic              unit_empty;
  logic [SLOT_W-1:0] unit_slot;
  logic [CNT_W-1:0]  unit_next;

  // Control
  logic             accept;
  logic             own;
  logic             pinnable;
  logic [CPU_W-1:0] own_idx;
  logic [CPU_W-1:0] pin_idx;
  logic             elsewhere;
  logic             run_sel;      // 0 stack A, 1 stack B
  logic             run_wr_en;
  logic             run_rd_en;
  logic [TW-1:0]    run_wdata;
  logic [CPU_W-1:0] cpu_sel;
  logic             cpu_wr_en;
  logic             cpu_rd_en;
  logic             push_drop;
  logic [CNT_W-1:0] act_cnt;
  logic [CNT_W-1:0] exp_cnt;
  logic [CNT_W-1:0] cpu_cnt;
  logic             out_free;
  logic             load_out;

  aets_pkg::pin_wr_t pin_wr;
  aets_pkg::pin_rd_t pin_rd;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state == ST_FINISH) && out_free;

  assign own       = (32'(cpu_q) < NUM_CPUS);
  assign pinnable  = (32'(tid_q) < MAX_THREADS);
  assign own_idx   = CPU_W'(cpu_q);
  assign pin_idx   = CPU_W'(pin_rd.cpu);
  assign elsewhere = pin_rd.valid && (32'(cur_thread) < MAX_THREADS) &&
                     (pin_rd.cpu != cpu_q);

  assign act_cnt = a_is_active ? stack_a_count : stack_b_count;
  assign exp_cnt = a_is_active ? stack_b_count : stack_a_count;
  assign cpu_cnt = cpu_counts[cpu_sel];

  aets_stack_unit #(
    .MAX_THREADS (MAX_THREADS)
  ) u_stack_unit (
    .count      (unit_cnt),
    .push       (unit_push),
    .full       (unit_full),
    .empty      (unit_empty),
    .slot       (unit_slot),
    .count_next (unit_next)
  );

  aets_pin_table u_pin_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (pin_wr),
    .rd_tid (run_rdata),
    .rd     (pin_rd)
  );

  // Per-state routing of the shared unit and memory ports
  always_comb begin
    unit_cnt   = '0;
    unit_push  = 1'b0;
    run_sel    = !a_is_active;
    run_wr_en  = 1'b0;
    run_rd_en  = 1'b0;
    run_wdata  = (cmd_q == aets_pkg::CMD_SCHED) ? othr_q : tid_q;
    cpu_sel    = own_idx;
    cpu_wr_en  = 1'b0;
    cpu_rd_en  = 1'b0;
    push_drop  = 1'b0;
    pin_wr.en  = 1'b0;
    pin_wr.tid = tid_q;
    pin_wr.cpu = cpu_q;
    case (state)
      ST_EXEC: begin
        case (cmd_q)
          aets_pkg::CMD_ADD: begin
            unit_cnt  = exp_cnt;
            unit_push = 1'b1;
            run_sel   = a_is_active;
            run_wr_en = !unit_full;
            push_drop = unit_full;
          end
          aets_pkg::CMD_WAKE: begin
            unit_cnt  = act_cnt;
            unit_push = 1'b1;
            run_sel   = !a_is_active;
            run_wr_en = !unit_full;
            push_drop = unit_full;
          end
          aets_pkg::CMD_SCHED: begin
            unit_cnt  = exp_cnt;
            unit_push = 1'b1;
            run_sel   = a_is_active;
            run_wr_en = requeue_q && !unit_full;
            push_drop = requeue_q && unit_full;
          end
          aets_pkg::CMD_PIN: begin
            pin_wr.en = own && pinnable;
          end
          default: begin
          end
        endcase
      end
      ST_CPU_CHK: begin
        cpu_sel   = own_idx;
        unit_cnt  = cpu_cnt;
        cpu_rd_en = own && !unit_empty;
      end
      ST_RUN_CHK, ST_RUN_POP: begin
        unit_cnt  = act_cnt;
        run_sel   = !a_is_active;
        run_rd_en = !unit_empty;
      end
      ST_PIN_CHK: begin
        cpu_sel   = pin_idx;
        unit_cnt  = cpu_cnt;
        unit_push = 1'b1;
        cpu_wr_en = elsewhere && !unit_full;
        push_drop = elsewhere && unit_full;
      end
      default: begin
      end
    endcase
  end

  // Run stacks A and B share one memory
  always_ff @(posedge clk) begin
    if (run_wr_en) begin
      run_mem[{run_sel, unit_slot}] <= run_wdata;
    end
    if (run_rd_en) begin
      run_rdata <= run_mem[{run_sel, unit_slot}];
    end
  end

  // Per-CPU stacks
  always_ff @(posedge clk) begin
    if (cpu_wr_en) begin
      cpu_mem[{cpu_sel, unit_slot}] <= cur_thread;
    end
    if (cpu_rd_en) begin
      cpu_rdata <= cpu_mem[{cpu_sel, unit_slot}];
    end
  end

  // Sequencer, stack counts and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      stack_a_count <= '0;
      stack_b_count <= '0;
      a_is_active   <= 1'b1;
      for (int i = 0; i < NUM_CPUS; i++) begin
        cpu_counts[i] <= '0;
      end
      out_valid     <= 1'b0;
    end else begin
      // result word handshake
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // count write-back from the shared unit
      if (run_wr_en || run_rd_en) begin
        if (run_sel) begin
          stack_b_count <= unit_next;
        end else begin
          stack_a_count <= unit_next;
        end
      end
      if (cpu_wr_en || cpu_rd_en) begin
        cpu_counts[cpu_sel] <= unit_next;
      end
      if (push_drop) begin
        status_q <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q     <= aets_pkg::cmd_t'(cmd);
            tid_q     <= thread_id;
            cpu_q     <= cpu_id;
            requeue_q <= outgoing_valid && outgoing_running;
            othr_q    <= outgoing_thread;
            found_q   <= 1'b0;
            next_q    <= '0;
            status_q  <= 1'b0;
            state     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd_q == aets_pkg::CMD_SCHED) begin
            state <= ST_CPU_CHK;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_CPU_CHK: begin
          if (cpu_rd_en) begin
            state <= ST_CPU_RD;
          end else begin
            state <= ST_RUN_CHK;
          end
        end
        ST_CPU_RD: begin
          found_q <= 1'b1;
          next_q  <= cpu_rdata;
          state   <= ST_FINISH;
        end
        ST_RUN_CHK: begin
          if (unit_empty) begin
            // active empty: swap with expired and look again
            a_is_active <= !a_is_active;
            state       <= ST_RUN_POP;
          end else begin
            state <= ST_RUN_RD;
          end
        end
        ST_RUN_POP: begin
          if (unit_empty) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_RUN_RD;
          end
        end
        ST_RUN_RD: begin
          cur_thread <= run_rdata;
          state      <= ST_PIN_CHK;
        end
        ST_PIN_CHK: begin
          if (elsewhere) begin
            state <= ST_CPU_CHK;
          end else begin
            found_q <= 1'b1;
            next_q  <= cur_thread;
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            next_valid    <= found_q;
            chosen_thread <= next_q;
            status        <= status_q;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_run_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(stack_a_count) <= MAX_THREADS) && (32'(stack_b_count) <= MAX_THREADS))
    else $error("run stack count beyond capacity");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result loaded outside the finish step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted word did not start execution");

  a_migrate_elsewhere: assert property (@(posedge clk) disable iff (rst)
    cpu_wr_en |-> (pin_rd.cpu != cpu_q) && (state == ST_PIN_CHK))
    else $error("migration into the requesting CPU's own stack");

  a_pin_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PIN_CHK) |-> ($past(state) == ST_RUN_RD))
    else $error("pin check without a popped thread");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MAXT         = aets_pkg::DEF_MAX_THREADS;
  localparam int NCPU         = aets_pkg::DEF_NUM_CPUS;
  localparam int TW           = aets_pkg::THREAD_W;
  localparam int CW           = aets_pkg::CPU_ID_W;
  localparam int DIR_ROWS     = 21;
  localparam int RAND_WORDS   = 650;
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int DRAIN_CYCLES = 20;

  // One command word; typed rows carry their expected pick
  typedef struct packed {
    aets_pkg::cmd_t op;
    logic [TW-1:0]  tid;
    logic [CW-1:0]  cpu;
    logic           ov;
    logic [TW-1:0]  othr;
    logic           orun;
    logic           typed;
    logic           nv;
    logic [TW-1:0]  nt;
    logic           st;
  } sched_word_t;

  typedef struct packed {
    logic          nv;
    logic [TW-1:0] nt;
    logic          st;
  } pick_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [aets_pkg::CMD_W-1:0] cmd = aets_pkg::CMD_ADD;
  logic [TW-1:0]              thread_id = '0;
  logic [CW-1:0]              cpu_id = '0;
  logic                       outgoing_valid = 1'b0;
  logic [TW-1:0]              outgoing_thread = '0;
  logic                       outgoing_running = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       next_valid;
  logic [TW-1:0]              chosen_thread;
  logic                       status;

  int send_idle_pct = 32;
  int recv_idle_pct = 65;
  int words_sent = 0;
  int errors = 0;
  int cycles = 0;

  pick_t expected_picks[$];

  // Shadow scheduler state; index 0 is stack A
  logic [TW-1:0] run_stk [2][MAXT];
  int            run_cnt [2];
  bit            active_idx;
  logic [TW-1:0] cpu_stk [NCPU][MAXT];
  int            cpu_cnt [NCPU];
  logic [2:0]    pin_of [MAXT];  // 0 unpinned, else cpu + 1

  sched_word_t dir_rows [DIR_ROWS] = '{
    // empty scheduler: idle
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd0, 1'b0, 6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_ADD,   6'd63, 2'd0, 1'b0, 6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_WAKE,  6'd0,  2'd3, 1'b1, 6'd63, 1'b1, 1'b1, 1'b0, 6'd0, 1'b0},
    // outgoing blocked, not requeued
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd3, 1'b1, 6'd63, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    // active empty: swap
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd0, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_PIN,   6'd5,  2'd2, 1'b0, 6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_PIN,   6'd63, 2'd3, 1'b1, 6'd63, 1'b1, 1'b1, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_WAKE,  6'd5,  2'd0, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_WAKE,  6'd42, 2'd0, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd1, 1'b1, 6'd42, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0},
    // pinned thread migrates, then swap
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd1, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd2, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    // duplicate queueing
    '{aets_pkg::CMD_ADD,   6'd63, 2'd0, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_ADD,   6'd63, 2'd0, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd3, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd0, 1'b1, 6'd0,  1'b1, 1'b0, 1'b0, 6'd0, 1'b0},
    // re-pin leaves the per-CPU copy in place
    '{aets_pkg::CMD_PIN,   6'd63, 2'd0, 1'b0, 6'd0,  1'b0, 1'b1, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd3, 1'b1, 6'd21, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd2, 1'b0, 6'd63, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd1, 1'b1, 6'd63, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0},
    '{aets_pkg::CMD_SCHED, 6'd0,  2'd0, 1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 6'd0, 1'b0}
  };

  active_expired_thread_scheduler DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .thread_id(thread_id),
    .cpu_id(cpu_id),
    .outgoing_valid(outgoing_valid),
    .outgoing_thread(outgoing_thread),
    .outgoing_running(outgoing_running),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .next_valid(next_valid),
    .chosen_thread(chosen_thread),
    .status(status)
  );

  always #10 clk = ~clk;

  // Push onto a run stack; returns 1 when dropped
  function automatic bit push_run(bit s, logic [TW-1:0] t);
    if (run_cnt[s] >= MAXT) return 1'b1;
    run_stk[s][run_cnt[s]] = t;
    run_cnt[s]++;
    return 1'b0;
  endfunction

  // Scheduler decision for one accepted word; updates the shadow state
  function automatic pick_t predict_pick(sched_word_t w);
    pick_t p;
    logic [TW-1:0] t;
    int pin;
    p = '0;
    case (w.op)
      aets_pkg::CMD_ADD:  p.st = push_run(~active_idx, w.tid);
      aets_pkg::CMD_WAKE: p.st = push_run(active_idx, w.tid);
      aets_pkg::CMD_PIN: begin
        if (w.cpu < NCPU && w.tid < MAXT) pin_of[w.tid] = 3'(w.cpu) + 3'd1;
      end
      default: begin
        if (w.ov && w.orun) p.st |= push_run(~active_idx, w.othr);
        for (int i = 0; i < 2 * MAXT + 4; i++) begin
          if (w.cpu < NCPU && cpu_cnt[w.cpu] > 0) begin
            cpu_cnt[w.cpu]--;
            p.nt = cpu_stk[w.cpu][cpu_cnt[w.cpu]];
            p.nv = 1'b1;
            break;
          end
          if (run_cnt[active_idx] == 0) active_idx = ~active_idx;
          if (run_cnt[active_idx] == 0) break;
          run_cnt[active_idx]--;
          t = run_stk[active_idx][run_cnt[active_idx]];
          pin = (t < MAXT) ? pin_of[t] : 0;
          if (pin != 0 && pin - 1 != w.cpu && pin - 1 < NCPU) begin
            // pinned elsewhere: migrate, drop if that CPU stack is full
            if (cpu_cnt[pin-1] >= MAXT) p.st = 1'b1;
            else begin
              cpu_stk[pin-1][cpu_cnt[pin-1]] = t;
              cpu_cnt[pin-1]++;
            end
            continue;
          end
          p.nt = t;
          p.nv = 1'b1;
          break;
        end
      end
    endcase
    return p;
  endfunction

  function automatic sched_word_t rand_word(aets_pkg::cmd_t op);
    sched_word_t w;
    w = '0;
    w.op   = op;
    w.tid  = TW'($urandom_range(63));
    w.cpu  = CW'($urandom_range(3));
    w.ov   = 1'($urandom_range(1));
    w.othr = TW'($urandom_range(63));
    w.orun = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic aets_pkg::cmd_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 22) return aets_pkg::CMD_ADD;
    if (r < 44) return aets_pkg::CMD_WAKE;
    if (r < 84) return aets_pkg::CMD_SCHED;
    return aets_pkg::CMD_PIN;
  endfunction

  // Drive one word, wait for accept, record its expected pick
  task automatic send_word(sched_word_t w);
    pick_t p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd              <= w.op;
    thread_id        <= w.tid;
    cpu_id           <= w.cpu;
    outgoing_valid   <= w.ov;
    outgoing_thread  <= w.othr;
    outgoing_running <= w.orun;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    p = predict_pick(w);
    if (w.typed) p = '{w.nv, w.nt, w.st};
    expected_picks.insert(expected_picks.size(), p);
    words_sent++;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    pick_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        report_mismatch("unexpected result word, chosen_thread", chosen_thread, 0);
      end else begin
        want = expected_picks.pop_front();
        if (next_valid !== want.nv) report_mismatch("next_valid", next_valid, want.nv);
        if (chosen_thread !== want.nt) begin
          report_mismatch("chosen_thread", chosen_thread, want.nt);
        end
        if (status !== want.st) report_mismatch("status", status, want.st);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", expected_picks.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    sched_word_t w;
    aets_pkg::cmd_t op;
    logic [CW-1:0] c, d;
    logic [TW-1:0] t;
    int r, n, done;
    bit flooded;
    flooded = 1'b0;
    active_idx = 1'b0;
    run_cnt = '{0, 0};
    foreach (cpu_cnt[i]) cpu_cnt[i] = 0;
    foreach (pin_of[i]) pin_of[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    // Random scenarios
    while (words_sent < DIR_ROWS + RAND_WORDS) begin
      done = words_sent - DIR_ROWS;
      if (done < RAND_WORDS / 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 65;
      end else if (done < 2 * RAND_WORDS / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 55) begin
        send_word(rand_word(pick_op()));
      end else if (r < 70) begin
        // run of schedules
        repeat ($urandom_range(3, 8)) send_word(rand_word(aets_pkg::CMD_SCHED));
      end else if (r < 78) begin
        // fill a run stack up to or past its capacity
        op = $urandom_range(1) ? aets_pkg::CMD_ADD : aets_pkg::CMD_WAKE;
        n = MAXT - run_cnt[(op == aets_pkg::CMD_ADD) ? ~active_idx : active_idx];
        repeat (n + $urandom_range(0, 3)) send_word(rand_word(op));
      end else if (r < 92 || flooded) begin
        // pinned thread queued several times, scheduled elsewhere then home
        t = TW'($urandom_range(63));
        c = CW'($urandom_range(3));
        w = rand_word(aets_pkg::CMD_PIN);
        w.tid = t;
        w.cpu = c;
        send_word(w);
        repeat ($urandom_range(2, 12)) begin
          w = rand_word($urandom_range(1) ? aets_pkg::CMD_ADD : aets_pkg::CMD_WAKE);
          w.tid = t;
          send_word(w);
        end
        repeat ($urandom_range(1, 4)) begin
          w = rand_word(aets_pkg::CMD_SCHED);
          w.cpu = c + CW'($urandom_range(1, 3));
          send_word(w);
        end
        w = rand_word(aets_pkg::CMD_SCHED);
        w.cpu = c;
        send_word(w);
      end else begin
        // overflow one CPU stack through migration
        flooded = 1'b1;
        c = CW'($urandom_range(3));
        d = c + CW'($urandom_range(1, 3));
        while (run_cnt[0] + run_cnt[1] != 0 || cpu_cnt[c] != 0) begin
          w = rand_word(aets_pkg::CMD_SCHED);
          w.cpu = c;
          w.ov = 1'b0;
          send_word(w);
        end
        t = TW'($urandom_range(63));
        w = rand_word(aets_pkg::CMD_PIN);
        w.tid = t;
        w.cpu = c;
        send_word(w);
        for (int i = 0; i < MAXT + 2; i++) begin
          w = rand_word(i[0] ? aets_pkg::CMD_ADD : aets_pkg::CMD_WAKE);
          w.tid = t;
          send_word(w);
        end
        while (cpu_cnt[d] != 0) begin
          w = rand_word(aets_pkg::CMD_SCHED);
          w.cpu = d;
          w.ov = 1'b0;
          send_word(w);
        end
        w = rand_word(aets_pkg::CMD_SCHED);
        w.cpu = d;
        w.ov = 1'b0;
        send_word(w);
        repeat (MAXT) begin
          w = rand_word(aets_pkg::CMD_SCHED);
          w.cpu = c;
          send_word(w);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== active_expired_thread_scheduler.f =====
rtl/core/aets_pkg.sv
rtl/core/aets_stack_unit.sv
rtl/core/aets_pin_table.sv
rtl/core/active_expired_thread_scheduler.sv
sim/testbench.sv
